// ===== rtl/core/stt_pkg.sv =====
// Shared types, codes and character helpers for the source text tokenizer.
// No dependencies; every other file in rtl/core imports this package.

package stt_pkg;

  // token kinds
  localparam logic [2:0] KIND_PUNCT       = 3'd0;
  localparam logic [2:0] KIND_ARROW       = 3'd1;
  localparam logic [2:0] KIND_NUMBER      = 3'd2;
  localparam logic [2:0] KIND_STRING      = 3'd3;
  localparam logic [2:0] KIND_NAME        = 3'd4;
  localparam logic [2:0] KIND_KW_FUNCTION = 3'd5;
  localparam logic [2:0] KIND_KW_RETURN   = 3'd6;
  localparam logic [2:0] KIND_UNTERM      = 3'd7;

  // characters of interest
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_GT        = 8'h3E;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_F   = 8'h66;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;

  localparam logic [3:0] LEN_FUNCTION = 4'd8;
  localparam logic [3:0] LEN_RETURN   = 4'd6;
  localparam logic [3:0] LEN_MAX      = 4'd15;

  // bundles held between front and back end
  localparam int QDEPTH = 4;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [5:0] {
    MODE_IDLE  = 6'b000001,
    MODE_MINUS = 6'b000010,
    MODE_NUM   = 6'b000100,
    MODE_NAME  = 6'b001000,
    MODE_STR   = 6'b010000,
    MODE_ESC   = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [2:0] token_kind;
    logic [7:0] text_byte;
    logic       is_text;
    logic       last;
  } event_t;

  // one byte's worth of results: first, optional second
  typedef struct packed {
    event_t first;
    event_t second;
    logic   two;
  } bundle_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c == 8'h28) || (c == 8'h29) || (c == 8'h7B) || (c == 8'h7D) || (c == 8'h3B);
  endfunction

  function automatic logic [7:0] function_char(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h66; // f
      3'd1:    r = 8'h75; // u
      3'd2:    r = 8'h6E; // n
      3'd3:    r = 8'h63; // c
      3'd4:    r = 8'h74; // t
      3'd5:    r = 8'h69; // i
      3'd6:    r = 8'h6F; // o
      default: r = 8'h6E; // n
    endcase
    return r;
  endfunction

  function automatic logic [7:0] return_char(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h72; // r
      3'd1:    r = 8'h65; // e
      3'd2:    r = 8'h74; // t
      3'd3:    r = 8'h75; // u
      3'd4:    r = 8'h72; // r
      3'd5:    r = 8'h6E; // n
      default: r = CH_NUL;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/stt_front.sv =====
// Front end: accepts source bytes, holds the lexer state and classifies
// each byte into a bundle of zero, one or two token events. Uses stt_pkg.

module stt_front import stt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] byte_in,
  input  logic       end_of_input,
  input  logic       q_full,
  output logic       q_push,
  output bundle_t    q_data
);

  mode_t      mode, mode_next;
  logic [3:0] match_index, match_index_next;
  logic       function_alive, function_alive_next;
  logic       return_alive, return_alive_next;

  logic       accept;
  logic       ev_a_valid, ev_b_valid, do_idle;
  event_t     ev_a;
  mode_t      idle_mode;
  logic       idle_ev_valid;
  event_t     idle_ev;
  logic       alnum;
  logic [2:0] name_kind;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign alnum    = is_alpha(byte_in) || is_digit(byte_in) || (byte_in == CH_UNDERSCORE);

  always_comb begin
    if (function_alive && (match_index == LEN_FUNCTION))
      name_kind = KIND_KW_FUNCTION;
    else if (return_alive && (match_index == LEN_RETURN))
      name_kind = KIND_KW_RETURN;
    else
      name_kind = KIND_NAME;
  end

  // what an idle lexer does with this byte
  always_comb begin
    idle_mode     = MODE_IDLE;
    idle_ev_valid = 1'b0;
    idle_ev       = '{token_kind: KIND_PUNCT, text_byte: byte_in, is_text: 1'b0, last: 1'b0};
    if (is_space(byte_in)) begin
      idle_mode = MODE_IDLE;
    end else if (byte_in == CH_MINUS) begin
      idle_mode = MODE_MINUS;
    end else if (is_punct(byte_in)) begin
      idle_ev_valid = 1'b1;
    end else if (is_digit(byte_in)) begin
      idle_mode          = MODE_NUM;
      idle_ev_valid      = 1'b1;
      idle_ev.token_kind = KIND_NUMBER;
      idle_ev.is_text    = 1'b1;
    end else if (byte_in == CH_QUOTE) begin
      idle_mode = MODE_STR;
    end else if (is_alpha(byte_in) || (byte_in == CH_UNDERSCORE)) begin
      idle_mode          = MODE_NAME;
      idle_ev_valid      = 1'b1;
      idle_ev.token_kind = KIND_NAME;
      idle_ev.is_text    = 1'b1;
    end
  end

  always_comb begin
    mode_next           = mode;
    match_index_next    = match_index;
    function_alive_next = function_alive;
    return_alive_next   = return_alive;
    ev_a_valid          = 1'b0;
    ev_a                = '{token_kind: KIND_PUNCT, text_byte: CH_NUL, is_text: 1'b0, last: 1'b0};
    do_idle             = 1'b0;

    if (end_of_input) begin
      ev_a_valid = 1'b1;
      case (mode)
        MODE_MINUS: ev_a.text_byte = CH_MINUS;
        MODE_NUM:   ev_a.token_kind = KIND_NUMBER;
        MODE_NAME:  ev_a.token_kind = name_kind;
        MODE_STR,
        MODE_ESC:   ev_a.token_kind = KIND_UNTERM;
        default:    ev_a_valid = 1'b0;
      endcase
      mode_next           = MODE_IDLE;
      match_index_next    = '0;
      function_alive_next = 1'b0;
      return_alive_next   = 1'b0;
    end else begin
      case (mode)
        MODE_MINUS: begin
          ev_a_valid = 1'b1;
          if (byte_in == CH_GT) begin
            ev_a.token_kind = KIND_ARROW;
            mode_next       = MODE_IDLE;
          end else begin
            ev_a.text_byte = CH_MINUS;
            do_idle        = 1'b1;
          end
        end
        MODE_NUM: begin
          ev_a_valid      = 1'b1;
          ev_a.token_kind = KIND_NUMBER;
          if (is_digit(byte_in)) begin
            ev_a.text_byte = byte_in;
            ev_a.is_text   = 1'b1;
          end else begin
            do_idle = 1'b1;
          end
        end
        MODE_NAME: begin
          ev_a_valid = 1'b1;
          if (alnum) begin
            ev_a.token_kind     = KIND_NAME;
            ev_a.text_byte      = byte_in;
            ev_a.is_text        = 1'b1;
            function_alive_next = function_alive && (match_index < LEN_FUNCTION) &&
                                  (function_char(match_index[2:0]) == byte_in);
            return_alive_next   = return_alive && (match_index < LEN_RETURN) &&
                                  (return_char(match_index[2:0]) == byte_in);
            if (match_index != LEN_MAX)
              match_index_next = match_index + 4'd1;
          end else begin
            ev_a.token_kind = name_kind;
            do_idle         = 1'b1;
          end
        end
        MODE_STR: begin
          ev_a.token_kind = KIND_STRING;
          if (byte_in == CH_QUOTE) begin
            ev_a_valid = 1'b1;
            mode_next  = MODE_IDLE;
          end else if (byte_in == CH_BACKSLASH) begin
            mode_next = MODE_ESC;
          end else begin
            ev_a_valid     = 1'b1;
            ev_a.text_byte = byte_in;
            ev_a.is_text   = 1'b1;
          end
        end
        MODE_ESC: begin
          mode_next       = MODE_STR;
          ev_a.token_kind = KIND_STRING;
          ev_a.is_text    = 1'b1;
          if (byte_in == CH_LOWER_N) begin
            ev_a_valid     = 1'b1;
            ev_a.text_byte = CH_NEWLINE;
          end else if (byte_in == CH_LOWER_T) begin
            ev_a_valid     = 1'b1;
            ev_a.text_byte = CH_TAB;
          end else if (byte_in == CH_QUOTE) begin
            ev_a_valid     = 1'b1;
            ev_a.text_byte = CH_QUOTE;
          end
        end
        default: do_idle = 1'b1;
      endcase

      if (do_idle) begin
        mode_next = idle_mode;
        if (idle_mode == MODE_NAME) begin
          // first name character: only f or r can still lead to a keyword
          match_index_next    = 4'd1;
          function_alive_next = (byte_in == CH_LOWER_F);
          return_alive_next   = (byte_in == CH_LOWER_R);
        end
      end
    end
  end

  assign ev_b_valid = do_idle && idle_ev_valid;

  always_comb begin
    q_data = '0;
    if (ev_a_valid) begin
      q_data.first      = ev_a;
      q_data.first.last = !ev_b_valid;
      q_data.second     = idle_ev;
      q_data.second.last = 1'b1;
      q_data.two        = ev_b_valid;
    end else begin
      q_data.first      = idle_ev;
      q_data.first.last = 1'b1;
      q_data.second     = idle_ev;
      q_data.two        = 1'b0;
    end
  end

  assign q_push = accept && (ev_a_valid || ev_b_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      match_index    <= '0;
      function_alive <= 1'b0;
      return_alive   <= 1'b0;
    end else if (accept) begin
      mode           <= mode_next;
      match_index    <= match_index_next;
      function_alive <= function_alive_next;
      return_alive   <= return_alive_next;
    end
  end

endmodule

// ===== rtl/core/stt_queue.sv =====
// Short queue of result bundles between front and back end.
// Depth from stt_pkg::QDEPTH; uses bundle_t from stt_pkg.

module stt_queue import stt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  output logic    full,
  input  logic    pop,
  output bundle_t pop_data,
  output logic    empty
);

  bundle_t             slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push, do_pop;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push)
      slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push)
        wr_ptr <= ptr_inc(wr_ptr);
      if (do_pop)
        rd_ptr <= ptr_inc(rd_ptr);
      if (do_push && !do_pop)
        count <= count + QCNT_W'(1);
      else if (do_pop && !do_push)
        count <= count - QCNT_W'(1);
    end
  end

endmodule

// ===== rtl/core/stt_back.sv =====
// Back end: takes bundles from the queue and sends their events one word
// at a time through a registered output. Uses stt_pkg.

module stt_back import stt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  bundle_t    q_data,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] token_kind,
  output logic [7:0] text_byte,
  output logic       is_text,
  output logic       last
);

  event_t out_ev;
  event_t pend_ev;
  logic   pend_valid;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign q_pop     = slot_free && !pend_valid && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (slot_free) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else begin
        out_valid  <= !q_empty;
        pend_valid <= !q_empty && q_data.two;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (pend_valid) begin
        out_ev <= pend_ev;
      end else if (!q_empty) begin
        out_ev  <= q_data.first;
        pend_ev <= q_data.second;
      end
    end
  end

  assign token_kind = out_ev.token_kind;
  assign text_byte  = out_ev.text_byte;
  assign is_text    = out_ev.is_text;
  assign last       = out_ev.last;

endmodule

// ===== rtl/core/source_text_tokenizer_top.sv =====
// Top level of the source text tokenizer: front end, bundle queue, back end.
// Depends on stt_pkg, stt_front, stt_queue and stt_back.

// Takes one source byte per cycle and streams token events: text words with
// is_text set while a number, name or string is open, then a closing word that
// carries the final kind (punctuation characters appear on the closing word).
// A byte that ends one token and starts another gives two words, and the output
// register sends one word per cycle while out_ready is high, so a four-bundle
// queue between the classifier and the output absorbs such extra words, and
// input ready drops only when that queue is full. Bytes that give no word push
// nothing into the queue. An accepted byte's first word passes a queue slot
// and then the output register. last marks the final word caused by each byte.

module source_text_tokenizer_top import stt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] byte_in,
  input  logic       end_of_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] token_kind,
  output logic [7:0] text_byte,
  output logic       is_text,
  output logic       last
);

  bundle_t push_data, pop_data;
  logic    push, pop, full, empty;

  stt_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .byte_in      (byte_in),
    .end_of_input (end_of_input),
    .q_full       (full),
    .q_push       (push),
    .q_data       (push_data)
  );

  stt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  stt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (empty),
    .q_data     (pop_data),
    .q_pop      (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .token_kind (token_kind),
    .text_byte  (text_byte),
    .is_text    (is_text),
    .last       (last)
  );

endmodule

// ===== rtl/core/stt_checker.sv =====
// Port-level checks for source_text_tokenizer_top, bound to the top level.
// Uses kind codes from stt_pkg.

module stt_checker import stt_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] token_kind,
  input logic [7:0] text_byte,
  input logic       is_text,
  input logic       last
);

  // a stalled word keeps its place
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(text_byte))
    else $error("output word dropped or changed while stalled");

  // nothing leaves the block straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // text words only belong to numbers, strings and names
  a_text_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_text |->
      token_kind == KIND_NUMBER || token_kind == KIND_STRING || token_kind == KIND_NAME)
    else $error("text word with a closing-only kind");

  // closing words other than punctuation carry a zero byte
  a_close_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_text && token_kind != KIND_PUNCT |-> text_byte == CH_NUL)
    else $error("closing word carries a byte");

  // a word that does not close its byte's results is followed by one that does
  a_pair_follow: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && last)
    else $error("second word of a pair missing");

endmodule

bind source_text_tokenizer_top stt_checker u_stt_checker (.*);

// ===== sim/source_text_tokenizer_top_test.sv =====
// Self-checking testbench for source_text_tokenizer_top: directed bytes, then random text.
// Words are checked against a local lexer model; depends on stt_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module source_text_tokenizer_top_test import stt_pkg::*;;

  localparam int NUM_DIR      = 29;
  localparam int RANDOM_ITEMS = 1520;
  localparam int RUN_LIMIT    = 1000000;
  localparam int DRAIN_CYCLES = 20;
  localparam event_t NO_EV    = '0;

  typedef struct {
    logic [7:0] b;
    logic       e;
  } src_t;

  // typed rows carry their words; the rest take the lexer model's words
  typedef struct {
    logic [7:0] b;
    logic       e;
    logic       typed;
    int         n;
    event_t     x0;
    event_t     x1;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] byte_in = 8'h00;
  logic       end_of_input = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] token_kind;
  logic [7:0] text_byte;
  logic       is_text;
  logic       last;

  int     cycle_count = 0;
  int     sent_count = 0;
  int     fail_count = 0;
  event_t tokens_due[$];
  src_t   src_q[$];

  // lexer model state
  mode_t      lx_mode;
  logic [3:0] lx_len;
  logic       lx_fn;
  logic       lx_ret;
  event_t     lx_out [0:1];
  int         lx_n;

  dir_row_t dir_rows [0:NUM_DIR-1] = '{
    '{8'hFF, 1'b1, 1'b1, 0, NO_EV, NO_EV},
    '{8'h28, 1'b0, 1'b1, 1, '{KIND_PUNCT, 8'h28, 1'b0, 1'b1}, NO_EV},
    '{CH_MINUS, 1'b0, 1'b1, 0, NO_EV, NO_EV},
    '{CH_GT, 1'b0, 1'b1, 1, '{KIND_ARROW, CH_NUL, 1'b0, 1'b1}, NO_EV},
    '{CH_MINUS, 1'b0, 1'b1, 0, NO_EV, NO_EV},
    '{8'h7D, 1'b0, 1'b1, 2, '{KIND_PUNCT, CH_MINUS, 1'b0, 1'b0},
      '{KIND_PUNCT, 8'h7D, 1'b0, 1'b1}},
    '{CH_MINUS, 1'b0, 1'b1, 0, NO_EV, NO_EV},
    '{8'h00, 1'b1, 1'b1, 1, '{KIND_PUNCT, CH_MINUS, 1'b0, 1'b1}, NO_EV},
    '{8'h39, 1'b0, 1'b1, 1, '{KIND_NUMBER, 8'h39, 1'b1, 1'b1}, NO_EV},
    '{8'h80, 1'b0, 1'b1, 1, '{KIND_NUMBER, CH_NUL, 1'b0, 1'b1}, NO_EV},
    '{CH_LOWER_R, 1'b0, 1'b0, 0, NO_EV, NO_EV},
    '{8'h65, 1'b0, 1'b0, 0, NO_EV, NO_EV},
    '{CH_LOWER_T, 1'b0, 1'b0, 0, NO_EV, NO_EV},
    '{8'h75, 1'b0, 1'b0, 0, NO_EV, NO_EV},
    '{CH_LOWER_R, 1'b0, 1'b0, 0, NO_EV, NO_EV},
    '{CH_LOWER_N, 1'b0, 1'b0, 0, NO_EV, NO_EV},
    '{8'h3B, 1'b0, 1'b0, 0, NO_EV, NO_EV},
    '{CH_QUOTE, 1'b0, 1'b1, 0, NO_EV, NO_EV},
    '{CH_BACKSLASH, 1'b0, 1'b0, 0, NO_EV, NO_EV},
    '{CH_LOWER_N, 1'b0, 1'b0, 0, NO_EV, NO_EV},
    '{CH_BACKSLASH, 1'b0, 1'b0, 0, NO_EV, NO_EV},
    '{CH_QUOTE, 1'b0, 1'b0, 0, NO_EV, NO_EV},
    '{CH_BACKSLASH, 1'b0, 1'b0, 0, NO_EV, NO_EV},
    '{CH_BACKSLASH, 1'b0, 1'b0, 0, NO_EV, NO_EV},
    '{8'hFF, 1'b0, 1'b0, 0, NO_EV, NO_EV},
    '{CH_BACKSLASH, 1'b0, 1'b0, 0, NO_EV, NO_EV},
    '{8'h41, 1'b1, 1'b1, 1, '{KIND_UNTERM, CH_NUL, 1'b0, 1'b1}, NO_EV},
    '{CH_UNDERSCORE, 1'b0, 1'b0, 0, NO_EV, NO_EV},
    '{8'h20, 1'b0, 1'b0, 0, NO_EV, NO_EV}
  };

  source_text_tokenizer_top u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .byte_in      (byte_in),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .text_byte    (text_byte),
    .is_text      (is_text),
    .last         (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------- lexer model

  function automatic logic digit_c(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic word_c(logic [7:0] c);
    return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_UNDERSCORE}) || digit_c(c);
  endfunction

  function automatic void lx_reset();
    lx_mode = MODE_IDLE;
    lx_len  = '0;
    lx_fn   = 1'b0;
    lx_ret  = 1'b0;
  endfunction

  function automatic void lx_emit(logic [2:0] kind, logic [7:0] b, logic txt);
    lx_out[lx_n] = '{kind, b, txt, 1'b0};
    lx_n++;
  endfunction

  function automatic void lx_track(logic [7:0] c);
    string kf;
    string kr;
    kf = "function";
    kr = "return";
    lx_fn  = lx_fn && (lx_len < LEN_FUNCTION) && (kf[lx_len] == c);
    lx_ret = lx_ret && (lx_len < LEN_RETURN) && (kr[lx_len] == c);
    if (lx_len != LEN_MAX) lx_len++;
  endfunction

  function automatic logic [2:0] lx_name_kind();
    if (lx_fn && lx_len == LEN_FUNCTION) return KIND_KW_FUNCTION;
    if (lx_ret && lx_len == LEN_RETURN) return KIND_KW_RETURN;
    return KIND_NAME;
  endfunction

  // byte seen with no token open
  function automatic void lx_fresh(logic [7:0] c);
    lx_mode = MODE_IDLE;
    if (c == CH_MINUS) begin
      lx_mode = MODE_MINUS;
    end else if (c inside {8'h28, 8'h29, 8'h7B, 8'h7D, 8'h3B}) begin
      lx_emit(KIND_PUNCT, c, 1'b0);
    end else if (digit_c(c)) begin
      lx_mode = MODE_NUM;
      lx_emit(KIND_NUMBER, c, 1'b1);
    end else if (c == CH_QUOTE) begin
      lx_mode = MODE_STR;
    end else if (word_c(c)) begin
      lx_mode = MODE_NAME;
      lx_len  = '0;
      lx_fn   = 1'b1;
      lx_ret  = 1'b1;
      lx_track(c);
      lx_emit(KIND_NAME, c, 1'b1);
    end
  endfunction

  function automatic void lex_step(logic [7:0] c, logic eoi);
    lx_n = 0;
    if (eoi) begin
      case (lx_mode)
        MODE_MINUS:         lx_emit(KIND_PUNCT, CH_MINUS, 1'b0);
        MODE_NUM:           lx_emit(KIND_NUMBER, CH_NUL, 1'b0);
        MODE_NAME:          lx_emit(lx_name_kind(), CH_NUL, 1'b0);
        MODE_STR, MODE_ESC: lx_emit(KIND_UNTERM, CH_NUL, 1'b0);
        default: ;
      endcase
      lx_reset();
    end else begin
      case (lx_mode)
        MODE_MINUS: begin
          if (c == CH_GT) begin
            lx_mode = MODE_IDLE;
            lx_emit(KIND_ARROW, CH_NUL, 1'b0);
          end else begin
            lx_emit(KIND_PUNCT, CH_MINUS, 1'b0);
            lx_fresh(c);
          end
        end
        MODE_NUM: begin
          if (digit_c(c)) begin
            lx_emit(KIND_NUMBER, c, 1'b1);
          end else begin
            lx_emit(KIND_NUMBER, CH_NUL, 1'b0);
            lx_fresh(c);
          end
        end
        MODE_NAME: begin
          if (word_c(c)) begin
            lx_track(c);
            lx_emit(KIND_NAME, c, 1'b1);
          end else begin
            lx_emit(lx_name_kind(), CH_NUL, 1'b0);
            lx_fresh(c);
          end
        end
        MODE_STR: begin
          if (c == CH_QUOTE) begin
            lx_mode = MODE_IDLE;
            lx_emit(KIND_STRING, CH_NUL, 1'b0);
          end else if (c == CH_BACKSLASH) begin
            lx_mode = MODE_ESC;
          end else begin
            lx_emit(KIND_STRING, c, 1'b1);
          end
        end
        MODE_ESC: begin
          lx_mode = MODE_STR;
          if (c == CH_LOWER_N) lx_emit(KIND_STRING, CH_NEWLINE, 1'b1);
          else if (c == CH_LOWER_T) lx_emit(KIND_STRING, CH_TAB, 1'b1);
          else if (c == CH_QUOTE) lx_emit(KIND_STRING, CH_QUOTE, 1'b1);
        end
        default: lx_fresh(c);
      endcase
    end
    if (lx_n > 0) lx_out[lx_n-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- random source text

  function automatic void add_src(logic [7:0] b, logic e);
    src_q.push_back('{b, e});
  endfunction

  function automatic logic [7:0] rnd_lead();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'(8'h61 + r);
    if (r < 52) return 8'(8'h41 + (r - 26));
    return CH_UNDERSCORE;
  endfunction

  function automatic logic [7:0] rnd_word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 52) return rnd_lead();
    if (r < 62) return 8'(8'h30 + (r - 52));
    return CH_UNDERSCORE;
  endfunction

  function automatic void gen_piece();
    int    pick;
    int    len;
    int    r;
    string w;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      // keywords, their prefixes and overlong forms
      w = ($urandom_range(0, 1) != 0) ? "function" : "return";
      len = w.len();
      if ($urandom_range(0, 3) == 0) len = $urandom_range(1, w.len() - 1);
      for (int i = 0; i < len; i++) add_src(w[i], 1'b0);
      if ($urandom_range(0, 3) == 0) add_src(rnd_word_char(), 1'b0);
    end else if (pick < 27) begin
      len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 20);
      add_src(rnd_lead(), 1'b0);
      for (int i = 1; i < len; i++) add_src(rnd_word_char(), 1'b0);
    end else if (pick < 39) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) add_src(8'(8'h30 + $urandom_range(0, 9)), 1'b0);
    end else if (pick < 55) begin
      add_src(CH_QUOTE, 1'b0);
      len = $urandom_range(0, 10);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 9);
        if (r < 3) begin
          add_src(CH_BACKSLASH, 1'b0);
          case ($urandom_range(0, 4))
            0:       add_src(CH_LOWER_N, 1'b0);
            1:       add_src(CH_LOWER_T, 1'b0);
            2:       add_src(CH_QUOTE, 1'b0);
            3:       add_src(CH_BACKSLASH, 1'b0);
            default: add_src(8'($urandom_range(0, 255)), 1'b0);
          endcase
        end else begin
          b = 8'($urandom_range(0, 255));
          if (b == CH_QUOTE || b == CH_BACKSLASH) b = 8'h7E;
          add_src(b, 1'b0);
        end
      end
      if ($urandom_range(0, 9) != 0) add_src(CH_QUOTE, 1'b0);
    end else if (pick < 67) begin
      case ($urandom_range(0, 4))
        0:       add_src(8'h28, 1'b0);
        1:       add_src(8'h29, 1'b0);
        2:       add_src(8'h7B, 1'b0);
        3:       add_src(8'h7D, 1'b0);
        default: add_src(8'h3B, 1'b0);
      endcase
    end else if (pick < 74) begin
      add_src(CH_MINUS, 1'b0);
      add_src(CH_GT, 1'b0);
    end else if (pick < 78) begin
      add_src(CH_MINUS, 1'b0);
    end else if (pick < 88) begin
      add_src(($urandom_range(0, 2) == 0) ? 8'(8'h09 + $urandom_range(0, 4)) : 8'h20, 1'b0);
    end else if (pick < 95) begin
      add_src(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      add_src(8'($urandom_range(0, 255)), 1'b1);
    end
    if ($urandom_range(0, 9) < 3) add_src(8'h20, 1'b0);
  endfunction

  // ---------------------------------------------------------------- driving and checking

  function automatic int tx_gap(int idx);
    int r;
    if ((idx / 150) % 4 == 1) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic offer_byte(input logic [7:0] b, input logic e, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    byte_in      <= b;
    end_of_input <= e;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  function automatic void queue_predicted();
    for (int i = 0; i < lx_n; i++) tokens_due.push_back(lx_out[i]);
  endfunction

  function automatic void log_fail(string msg);
    if (fail_count < 10) $display("%s", msg);
    fail_count++;
  endfunction

  task automatic check_word();
    event_t want;
    if (tokens_due.size() == 0) begin
      log_fail($sformatf("unexpected word kind=%0d byte=%02h text=%0b last=%0b",
                         token_kind, text_byte, is_text, last));
    end else begin
      want = tokens_due.pop_front();
      if (token_kind !== want.token_kind || text_byte !== want.text_byte ||
          is_text !== want.is_text || last !== want.last)
        log_fail($sformatf({"mismatch: exp kind=%0d byte=%02h text=%0b last=%0b, ",
                            "got kind=%0d byte=%02h text=%0b last=%0b"},
                           want.token_kind, want.text_byte, want.is_text, want.last,
                           token_kind, text_byte, is_text, last));
    end
  endtask

  // receiver: random stalls, calm stretches, and one long hold-off to fill the block
  initial begin
    int   hold_left;
    int   stall_left;
    int   r;
    bit   held;
    logic rdy;
    hold_left  = 0;
    stall_left = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) check_word();
      rdy = 1'b1;
      if (!held && sent_count >= 600) begin
        held      = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if ((cycle_count / 400) % 5 != 3) begin
        r = $urandom_range(0, 999);
        if (r < 120) stall_left = $urandom_range(1, 3);
        else if (r < 150) stall_left = $urandom_range(4, 12);
        else if (r < 156) stall_left = $urandom_range(20, 40);
      end
      out_ready <= rdy;
    end
  end

  // sender
  initial begin
    lx_reset();
    while (src_q.size() < RANDOM_ITEMS) gen_piece();
    add_src(8'h00, 1'b1);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIR; i++) begin
      offer_byte(dir_rows[i].b, dir_rows[i].e, tx_gap(i));
      lex_step(dir_rows[i].b, dir_rows[i].e);
      if (dir_rows[i].typed) begin
        if (dir_rows[i].n > 0) tokens_due.push_back(dir_rows[i].x0);
        if (dir_rows[i].n > 1) tokens_due.push_back(dir_rows[i].x1);
      end else begin
        queue_predicted();
      end
    end

    foreach (src_q[i]) begin
      offer_byte(src_q[i].b, src_q[i].e, tx_gap(i + NUM_DIR));
      lex_step(src_q[i].b, src_q[i].e);
      queue_predicted();
    end
    in_valid <= 1'b0;

    while (tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== source_text_tokenizer_top.f =====
rtl/core/stt_pkg.sv
rtl/core/stt_front.sv
rtl/core/stt_queue.sv
rtl/core/stt_back.sv
rtl/core/source_text_tokenizer_top.sv
rtl/core/stt_checker.sv
sim/source_text_tokenizer_top_test.sv
